// ===== sv/jet_pkg.sv =====
// Shared types, constants and codes for the Julia escape-time iterator.
`timescale 1ns / 1ps

package jet_pkg;

   localparam int DATA_W             = 32;
   localparam int PROD_W             = 64;
   localparam int Q8_W               = 8;
   localparam int COLOR_W            = 13;
   localparam int CSR_INDEX_W        = 2;
   localparam int DEFAULT_FRAC_BITS  = 28;
   localparam int DEFAULT_COUNT_BITS = 12;

   localparam logic [COLOR_W-1:0] COLOR_COUNT_RESET = COLOR_W'(500);
   localparam logic               SMOOTH_MODE_RESET = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_C_REAL      = 2'd0,
      CSR_C_IMAG      = 2'd1,
      CSR_COLOR_COUNT = 2'd2,
      CSR_SMOOTH_MODE = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_CROSS,
      ST_UPDATE,
      ST_FRAC,
      ST_DONE
   } jet_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== sv/julia_escape_time_iterator_unit.sv =====
// Top level of the Julia escape-time iterator: sequencer, state and registers.
`timescale 1ns / 1ps
//
// Usage:
//   req channel: one request carries a start point z0 (req_start_real,
//   req_start_imag, signed fixed point with FRAC_BITS fraction bits). It is
//   taken when req_valid is high and req_stall is low.
//   rsp channel: one response per request (escape count, Q0.8 smooth
//   fraction, escaped flag), held in output registers until rsp_stall is low.
//   csr port: write c_real, c_imag, color_count and smooth_mode by index
//   while the unit is idle.
//   Schedule: one shared 32x32 multiplier is used three times per iteration,
//   in the states SQ_X, SQ_Y and CROSS, followed by UPDATE. When the limit is
//   zero the response follows the request without any iteration; on an escape
//   in smooth mode it also waits for the smooth fraction divider. The next
//   request is taken only after the response has left and the unit is idle
//   again. req_stall stays high from acceptance until the response leaves.
//   Reset: synchronous; the registers return to c = 0, color_count 500,
//   smooth mode on, and the unit comes up idle with no response pending.
//   A stalled response holds its fields and blocks the next request.

module julia_escape_time_iterator_unit #(
   parameter int FRAC_BITS  = jet_pkg::DEFAULT_FRAC_BITS,
   parameter int COUNT_BITS = jet_pkg::DEFAULT_COUNT_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [jet_pkg::DATA_W-1:0]      req_start_real,
   input  logic signed [jet_pkg::DATA_W-1:0]      req_start_imag,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [COUNT_BITS-1:0]                  rsp_escape_count,
   output logic [jet_pkg::Q8_W-1:0]               rsp_escape_fraction,
   output logic                                   rsp_escaped,
   // configuration writes
   input  logic                                   csr_write,
   input  logic [jet_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [jet_pkg::DATA_W-1:0]             csr_wdata
);
   import jet_pkg::*;

   // Escape threshold 4 in the squared scale; out of reach for wide fractions.
   localparam int              THRESH_SHIFT = 2 * FRAC_BITS + 2;
   localparam logic            CAN_ESCAPE   = (THRESH_SHIFT <= 62);
   localparam logic [PROD_W-1:0] THRESH     =
      CAN_ESCAPE ? (PROD_W'(1) << THRESH_SHIFT) : '0;
   localparam int              LIM_W        = 18;
   localparam logic signed [LIM_W-1:0] MAX_COUNT = LIM_W'((1 << COUNT_BITS) - 1);

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = PROD_W'(32'sh7FFF_FFFF);
      lo = PROD_W'(32'sh8000_0000);
      if (v > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end else begin
         return v[DATA_W-1:0];
      end
   endfunction

   // configuration registers
   logic signed [DATA_W-1:0] c_real_ff;
   logic signed [DATA_W-1:0] c_imag_ff;
   logic [COLOR_W-1:0]       color_count_ff;
   logic                     smooth_mode_ff;

   // sequencer and datapath
   jet_state_type             state_ff, state_in;
   logic signed [DATA_W-1:0]  x_ff, x_in;
   logic signed [DATA_W-1:0]  y_ff, y_in;
   logic signed [PROD_W-1:0]  xx_ff, xx_in;
   logic signed [PROD_W-1:0]  yy_ff, yy_in;
   logic                      first_ff, first_in;
   logic [COUNT_BITS-1:0]     step_ff, step_in;
   logic [COUNT_BITS-1:0]     limit_ff, limit_in;
   logic [COUNT_BITS-1:0]     count_ff, count_in;
   logic [Q8_W-1:0]           frac_ff, frac_in;
   logic                      esc_ff, esc_in;

   logic signed [DATA_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0]  prod;
   logic                      div_start;
   logic [PROD_W-1:0]         mag;
   logic                      over;
   div_status_type            div_status;
   logic [Q8_W-1:0]           div_quotient;
   logic signed [LIM_W-1:0]   lim_raw;
   logic signed [PROD_W-1:0]  re_sum, im_sum;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         c_real_ff      <= '0;
         c_imag_ff      <= '0;
         color_count_ff <= COLOR_COUNT_RESET;
         smooth_mode_ff <= SMOOTH_MODE_RESET;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_C_REAL:      c_real_ff      <= csr_wdata;
            CSR_C_IMAG:      c_imag_ff      <= csr_wdata;
            CSR_COLOR_COUNT: color_count_ff <= csr_wdata[COLOR_W-1:0];
            CSR_SMOOTH_MODE: smooth_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------- shared units
   jet_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   jet_frac_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (mag),
      .den      (mag + THRESH),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // Multiplier schedule: x*x in SQ_X, y*y in SQ_Y, x*y in CROSS; each
   // product lands one state later.
   always_comb begin
      case (state_ff)
         ST_SQ_Y: begin
            mul_a = y_ff;
            mul_b = y_ff;
         end
         ST_CROSS: begin
            mul_a = x_ff;
            mul_b = y_ff;
         end
         default: begin
            mul_a = x_ff;
            mul_b = x_ff;
         end
      endcase
   end

   // Iteration limit: palette size less one or two, clamped to the count range.
   always_comb begin
      lim_raw = LIM_W'($signed({1'b0, color_count_ff})) - (smooth_mode_ff ? LIM_W'(2) : LIM_W'(1));
      if (lim_raw < 0) begin
         limit_in = '0;
      end else if (lim_raw > MAX_COUNT) begin
         limit_in = MAX_COUNT[COUNT_BITS-1:0];
      end else begin
         limit_in = lim_raw[COUNT_BITS-1:0];
      end
   end

   // |z|^2 of the freshly updated point: x*x held, y*y arriving now.
   assign mag  = xx_ff + prod;
   assign over = CAN_ESCAPE && (mag > THRESH);

   assign re_sum = ((xx_ff - yy_ff) >>> FRAC_BITS) + PROD_W'(c_real_ff);
   assign im_sum = (prod >>> (FRAC_BITS - 1)) + PROD_W'(c_imag_ff);

   // -------------------------------------------------------------- sequencer
   always_comb begin
      state_in  = state_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      xx_in     = xx_ff;
      yy_in     = yy_ff;
      first_in  = first_ff;
      step_in   = step_ff;
      count_in  = count_ff;
      frac_in   = frac_ff;
      esc_in    = esc_ff;
      div_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in     = req_start_real;
               y_in     = req_start_imag;
               first_in = 1'b1;
               step_in  = '0;
               count_in = '0;
               frac_in  = '0;
               esc_in   = 1'b0;
               state_in = (limit_in == '0) ? ST_DONE : ST_SQ_X;
            end
         end
         ST_SQ_X: begin
            state_in = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            xx_in    = prod;
            state_in = ST_CROSS;
         end
         ST_CROSS: begin
            yy_in    = prod;
            state_in = ST_UPDATE;
            if (!first_ff) begin
               if (over) begin
                  count_in = step_ff;
                  esc_in   = 1'b1;
                  if (smooth_mode_ff) begin
                     div_start = 1'b1;
                     state_in  = ST_FRAC;
                  end else begin
                     state_in = ST_DONE;
                  end
               end else if (step_ff == limit_ff - 1'b1) begin
                  count_in = limit_ff;
                  state_in = ST_DONE;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         ST_UPDATE: begin
            // advance z = z*z + c with saturation
            x_in     = sat32(re_sum);
            y_in     = sat32(im_sum);
            first_in = 1'b0;
            state_in = ST_SQ_X;
         end
         ST_FRAC: begin
            if (div_status.done) begin
               frac_in  = div_quotient;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b0;
         step_ff  <= '0;
         limit_ff <= '0;
         count_ff <= '0;
         frac_ff  <= '0;
         esc_ff   <= 1'b0;
      end else begin
         first_ff <= first_in;
         step_ff  <= step_in;
         count_ff <= count_in;
         frac_ff  <= frac_in;
         esc_ff   <= esc_in;
         if (state_ff == ST_IDLE && req_valid) begin
            limit_ff <= limit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff  <= x_in;
      y_ff  <= y_in;
      xx_ff <= xx_in;
      yy_ff <= yy_in;
   end

   // ---------------------------------------------------------------- outputs
   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = (state_ff == ST_DONE);
   assign rsp_escape_count    = count_ff;
   assign rsp_escape_fraction = frac_ff;
   assign rsp_escaped         = esc_ff;

`ifndef SYNTHESIS
   // one request in flight: a response pending blocks new requests
   a_single_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while a response is pending");

   // an escape is reported strictly below the iteration limit
   a_escape_below_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_escaped) |-> (rsp_escape_count < limit_ff))
      else $error("escape count not below the limit");

   // no escape means the full limit ran and there is no fraction
   a_no_escape_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_escaped) |->
         (rsp_escape_count == limit_ff && rsp_escape_fraction == '0))
      else $error("non-escaped response has wrong count or fraction");

   // smooth fraction m/(m+4) with m > 4 is at least one half
   a_frac_half: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_escaped && smooth_mode_ff) |-> rsp_escape_fraction[Q8_W-1])
      else $error("smooth fraction below one half");
`endif

endmodule

// ===== sv/jet_mul.sv =====
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module jet_mul (
   input  logic                              clock,
   input  logic signed [jet_pkg::DATA_W-1:0] mul_a,
   input  logic signed [jet_pkg::DATA_W-1:0] mul_b,
   output logic signed [jet_pkg::PROD_W-1:0] prod_ff
);
   import jet_pkg::*;

   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== sv/jet_frac_div.sv =====
// Bit-serial restoring divider for the Q0.8 smooth fraction.
`timescale 1ns / 1ps

module jet_frac_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [jet_pkg::PROD_W-1:0]  num,
   input  logic [jet_pkg::PROD_W-1:0]  den,
   output jet_pkg::div_status_type     status,
   output logic [jet_pkg::Q8_W-1:0]    quotient
);
   import jet_pkg::*;

   localparam int CNT_W = $clog2(Q8_W);

   logic [PROD_W-1:0] n_ff, n_in;
   logic [PROD_W-1:0] d_ff, d_in;
   logic [Q8_W-1:0]   q_ff, q_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [PROD_W-1:0] rest;

   assign rest = d_ff - n_ff;

   always_comb begin
      n_in    = n_ff;
      d_in    = d_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         n_in    = num;
         d_in    = den;
         q_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one quotient bit: compare 2n against d without overflow
         if (n_ff >= rest) begin
            n_in = n_ff - rest;
            q_in = {q_ff[Q8_W-2:0], 1'b1};
         end else begin
            n_in = n_ff + n_ff;
            q_in = {q_ff[Q8_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(Q8_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      d_ff <= d_in;
      q_ff <= q_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = q_ff;

endmodule
